// File: rtl/pdwa_pkg.sv
`default_nettype none
package pdwa_pkg;

	localparam int DESTINATIONS_DEF = 16;
	localparam int CAPACITY_DEF     = 64;
	localparam int MAX_WORDS_DEF    = 64;
	localparam int OUT_DEPTH_DEF    = 4;
	localparam int CMD_DEPTH_DEF    = 2;

	localparam int CFG_W  = 7;
	localparam int DIDX_W = 8;
	localparam int CNT_W  = 7;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_FLUSH = 3'd1;
	localparam logic [2:0] MODE_FORCE = 3'd2;
	localparam logic [2:0] MODE_ALL   = 3'd3;
	localparam logic [2:0] MODE_QUERY = 3'd4;

	localparam logic KIND_MSG   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic REG_PERIOD   = 1'b0;
	localparam logic REG_OWN_RANK = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  destination;
		logic [63:0] value;
		logic [7:0]  tag;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] word;
		logic [3:0]  dest_out;
		logic [7:0]  tag_out;
		logic [3:0]  source_rank;
		logic        last;
		logic        needs_flush;
	} out_t;

	typedef struct packed {
		logic              query;
		logic              nf;
		logic [DIDX_W-1:0] dest;
		logic [7:0]        tag;
		logic [CNT_W-1:0]  count;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/pdwa_ram.sv
`default_nettype none
module pdwa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/pdwa_fifo.sv
`default_nettype none
module pdwa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty,
	output logic                  full,
	output logic      [CW-1:0]    count
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem[rptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/pdwa_front.sv
`default_nettype none
module pdwa_front #(
	parameter int DESTINATIONS = 16,
	parameter int CAPACITY     = 64,
	parameter int MAX_WORDS    = 64,
	parameter int AW           = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire pdwa_pkg::in_t           item,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [pdwa_pkg::CFG_W-1:0] cfg_data,
	output logic      [3:0]              own_rank,
	output logic                         ram_we,
	output logic      [AW-1:0]           ram_waddr,
	output logic      [63:0]             ram_wdata,
	output logic                         cmd_push,
	output pdwa_pkg::cmd_t               cmd,
	input  wire logic                    cmd_full,
	input  wire logic                    flush_done
);
	import pdwa_pkg::*;

	localparam int DI_W = (DESTINATIONS > 1) ? $clog2(DESTINATIONS) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic [CW-1:0]   cnt_q [DESTINATIONS];
	logic            st_q;
	logic [DI_W-1:0] scan_q;
	logic [7:0]      scan_tag_q;
	logic [6:0]      period_q;
	logic [7:0]      acc_q;
	logic [6:0]      thr_q;
	logic            thr_busy_q;
	logic [3:0]      own_rank_q;
	logic            flush_out_q;

	logic            accept;
	logic            dest_valid;
	logic [DI_W-1:0] rd_idx;
	logic [CW-1:0]   cur_cnt;
	logic            nonzero;
	logic            reached;
	logic            inc_cnt;
	logic            clear_cnt;
	logic            start_scan;
	logic [7:0]      acc_next;

	assign full       = (st_q != ST_IDLE) || thr_busy_q || cmd_full || flush_out_q;
	assign accept     = push && !full;
	assign dest_valid = 9'(item.destination) < 9'(DESTINATIONS);
	assign rd_idx     = (st_q == ST_SCAN) ? scan_q : DI_W'(item.destination);
	assign cur_cnt    = cnt_q[rd_idx];
	assign nonzero    = (cur_cnt != '0);
	assign reached    = 8'(cur_cnt) >= 8'(thr_q);
	assign own_rank   = own_rank_q;
	assign acc_next   = acc_q + 8'(period_q);

	assign ram_waddr = AW'(rd_idx) * AW'(CAPACITY) + AW'(cur_cnt);
	assign ram_wdata = item.value;

	always_comb begin
		ram_we     = 1'b0;
		cmd_push   = 1'b0;
		cmd        = '0;
		inc_cnt    = 1'b0;
		clear_cnt  = 1'b0;
		start_scan = 1'b0;
		if (st_q == ST_SCAN) begin
			if (nonzero && !cmd_full) begin
				cmd_push  = 1'b1;
				cmd.dest  = DIDX_W'(scan_q);
				cmd.tag   = scan_tag_q;
				cmd.count = CNT_W'(cur_cnt);
				clear_cnt = 1'b1;
			end
		end else if (accept) begin
			unique case (item.mode)
				MODE_ADD: begin
					if (dest_valid && cur_cnt < CW'(CAPACITY)) begin
						ram_we  = 1'b1;
						inc_cnt = 1'b1;
					end
				end
				MODE_FLUSH, MODE_FORCE: begin
					if (dest_valid && nonzero && (reached || item.mode == MODE_FORCE)) begin
						cmd_push  = 1'b1;
						cmd.dest  = DIDX_W'(item.destination);
						cmd.tag   = item.tag;
						cmd.count = CNT_W'(cur_cnt);
						clear_cnt = 1'b1;
					end
				end
				MODE_ALL: begin
					start_scan = 1'b1;
				end
				MODE_QUERY: begin
					cmd_push  = 1'b1;
					cmd.query = 1'b1;
					cmd.dest  = DIDX_W'(item.destination);
					cmd.nf    = dest_valid ? reached : (thr_q == '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DESTINATIONS; i++) begin
				cnt_q[i] <= '0;
			end
			st_q        <= ST_IDLE;
			scan_q      <= '0;
			flush_out_q <= 1'b0;
			period_q    <= 7'd1;
			acc_q       <= '0;
			thr_q       <= 7'(MAX_WORDS);
			thr_busy_q  <= 1'b0;
			own_rank_q  <= '0;
		end else begin
			if (inc_cnt) begin
				cnt_q[rd_idx] <= cur_cnt + 1'b1;
			end else if (clear_cnt) begin
				cnt_q[rd_idx] <= '0;
			end

			if (start_scan) begin
				st_q   <= ST_SCAN;
				scan_q <= '0;
			end else if (st_q == ST_SCAN) begin
				if (clear_cnt) begin
					st_q <= ST_IDLE;
				end else if (!nonzero) begin
					if (scan_q == DI_W'(DESTINATIONS - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
			end

			if (cmd_push && !cmd.query) begin
				flush_out_q <= 1'b1;
			end else if (flush_done) begin
				flush_out_q <= 1'b0;
			end

			// threshold is built up one period step per cycle while cfg_we stays low
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PERIOD: begin
						period_q   <= (cfg_data == '0) ? 7'd1 : cfg_data;
						acc_q      <= '0;
						thr_busy_q <= 1'b1;
					end
					REG_OWN_RANK: begin
						own_rank_q <= cfg_data[3:0];
					end
					default: begin
					end
				endcase
			end else if (thr_busy_q) begin
				if (acc_next <= 8'(MAX_WORDS)) begin
					acc_q <= acc_next;
				end else begin
					thr_q      <= 7'(acc_q);
					thr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			scan_tag_q <= item.tag;
		end
	end

endmodule
`default_nettype wire

// File: rtl/pdwa_back.sv
`default_nettype none
module pdwa_back #(
	parameter int CAPACITY  = 64,
	parameter int AW        = 10,
	parameter int OUT_DEPTH = 4,
	localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	input  wire pdwa_pkg::cmd_t cmd,
	output logic      [AW-1:0]  ram_raddr,
	input  wire logic [63:0]    ram_rdata,
	input  wire logic [3:0]     own_rank,
	input  wire logic [OCW-1:0] out_count,
	output logic                out_push,
	output pdwa_pkg::out_t      out_data,
	output logic                flush_done
);
	import pdwa_pkg::*;

	logic              stream_q;
	logic [DIDX_W-1:0] dest_q;
	logic [7:0]        tag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;

	logic              v_s1;
	logic              query_s1;
	logic              nf_s1;
	logic [3:0]        dest_s1;
	logic [7:0]        tag_s1;
	logic              last_s1;

	logic              space;
	logic              issue_rd;
	logic              last_rd;

	// credit covers the result still in the output stage, a ram word or a query answer
	assign space      = ((OCW + 1)'(out_count) + (OCW + 1)'(v_s1)) < (OCW + 1)'(OUT_DEPTH);
	assign cmd_pop    = !stream_q && !cmd_empty && space;
	assign issue_rd   = stream_q && space;
	assign last_rd    = ((idx_q + 1'b1) == cnt_q);
	assign flush_done = issue_rd && last_rd;
	assign ram_raddr  = AW'(dest_q) * AW'(CAPACITY) + AW'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= (cmd_pop && cmd.query) || issue_rd;
			if (cmd_pop && !cmd.query) begin
				stream_q <= 1'b1;
			end else if (flush_done) begin
				stream_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			dest_q   <= cmd.dest;
			tag_q    <= cmd.tag;
			cnt_q    <= cmd.count;
			idx_q    <= '0;
			query_s1 <= 1'b1;
			nf_s1    <= cmd.nf;
			dest_s1  <= cmd.dest[3:0];
			tag_s1   <= '0;
			last_s1  <= 1'b1;
		end else if (issue_rd) begin
			idx_q    <= idx_q + 1'b1;
			query_s1 <= 1'b0;
			nf_s1    <= 1'b0;
			dest_s1  <= dest_q[3:0];
			tag_s1   <= tag_q;
			last_s1  <= last_rd;
		end
	end

	assign out_push = v_s1;

	always_comb begin
		out_data.kind        = query_s1 ? KIND_QUERY : KIND_MSG;
		out_data.word        = query_s1 ? 64'd0 : ram_rdata;
		out_data.dest_out    = dest_s1;
		out_data.tag_out     = tag_s1;
		out_data.source_rank = own_rank;
		out_data.last        = last_s1;
		out_data.needs_flush = nf_s1;
	end

endmodule
`default_nettype wire

// File: rtl/per_destination_word_aggregator.sv
// per-destination word aggregator
// input channel: push / full with one item per word (mode, destination, value, tag);
// an item is taken on a clock edge with push high and full low
// result channel: empty / pop; the oldest result sits on the result port while empty
// is low and leaves on an edge with pop high
// config: cfg_we, cfg_index, cfg_data; period at index 0, own_rank at index 1
// add and query can be pushed every cycle while full stays low
// a query answer passes the command queue and the output stage register
// a flush of n words reads the word ram once per cycle while the output queue has room;
// full stays high until the last read is issued
// flush all first scans the fill counts, one destination per cycle, and flushes only
// the first non-empty one; writing period rebuilds the threshold one step per cycle
// while cfg_we stays low, with full high
// a stalled receiver fills the output queue; word ram reads then pause and input backs up
// reset empties every buffer, sets period 1, own_rank 0 and drops all pending results
`default_nettype none
module per_destination_word_aggregator #(
	parameter int DESTINATIONS = pdwa_pkg::DESTINATIONS_DEF,
	parameter int CAPACITY     = pdwa_pkg::CAPACITY_DEF,
	parameter int MAX_WORDS    = pdwa_pkg::MAX_WORDS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire pdwa_pkg::in_t              item,
	output logic                            empty,
	input  wire logic                       pop,
	output pdwa_pkg::out_t                  result,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [pdwa_pkg::CFG_W-1:0] cfg_data
);
	import pdwa_pkg::*;

	localparam int RAM_DEPTH = DESTINATIONS * CAPACITY;
	localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int OCW       = $clog2(OUT_DEPTH_DEF + 1);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	logic          cmd_push;
	cmd_t          cmd_in;
	logic          cmd_full;
	logic          cmd_empty;
	logic          cmd_pop;
	cmd_t          cmd_out;

	logic [3:0]    own_rank;
	logic          flush_done;
	logic [OCW-1:0] out_count;
	logic          out_push;
	out_t          out_data;

	pdwa_front #(
		.DESTINATIONS(DESTINATIONS),
		.CAPACITY    (CAPACITY),
		.MAX_WORDS   (MAX_WORDS),
		.AW          (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.own_rank  (own_rank),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full),
		.flush_done(flush_done)
	);

	pdwa_ram #(
		.WIDTH(64),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pdwa_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH_DEF)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty),
		.full   (cmd_full),
		.count  ()
	);

	pdwa_back #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.OUT_DEPTH(OUT_DEPTH_DEF)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_out),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.own_rank  (own_rank),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_data),
		.flush_done(flush_done)
	);

	pdwa_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OUT_DEPTH_DEF)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wr_data(out_data),
		.rd_en  (pop),
		.rd_data(result),
		.empty  (empty),
		.full   (),
		.count  (out_count)
	);

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import pdwa_pkg::*;

	localparam int NDEST        = DESTINATIONS_DEF;
	localparam int NSLOT        = CAPACITY_DEF;
	localparam int MAXW         = MAX_WORDS_DEF;
	localparam int SETTLE_WAIT  = MAXW + 24;
	localparam int TAIL_WAIT    = 100;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASE_WORDS  = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_t         item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_t        result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	// predicted block state
	logic [63:0] word_buf [NDEST][NSLOT];
	int          fill_level [NDEST] = '{default: 0};
	int          flush_threshold = MAXW;
	logic [3:0]  cur_rank = '0;
	out_t        outbound [$];

	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          no_gaps = 1'b0;
	logic [3:0]  hot_dest = '0;
	out_t        oldest;

	per_destination_word_aggregator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic out_t make_result(input logic k, input logic [63:0] w, input logic [3:0] d,
			input logic [7:0] t, input logic l, input logic nf);
		out_t r;
		r.kind        = k;
		r.word        = w;
		r.dest_out    = d;
		r.tag_out     = t;
		r.source_rank = cur_rank;
		r.last        = l;
		r.needs_flush = nf;
		return r;
	endfunction

	function automatic void send_out_buffer(input int d, input logic [7:0] t);
		for (int i = 0; i < fill_level[d]; i++)
			outbound = {outbound, make_result(KIND_MSG, word_buf[d][i], d[3:0], t,
				i == fill_level[d] - 1, 1'b0)};
		fill_level[d] = 0;
	endfunction

	function automatic void aggregate(input in_t w);
		int d;
		d = int'(w.destination);
		case (w.mode)
			MODE_ADD: begin
				if (fill_level[d] < NSLOT) begin
					word_buf[d][fill_level[d]] = w.value;
					fill_level[d]++;
				end
			end
			MODE_FLUSH: begin
				if (fill_level[d] != 0 && fill_level[d] >= flush_threshold)
					send_out_buffer(d, w.tag);
			end
			MODE_FORCE: begin
				if (fill_level[d] != 0)
					send_out_buffer(d, w.tag);
			end
			MODE_ALL: begin
				for (int i = 0; i < NDEST; i++)
					if (fill_level[i] != 0) begin
						send_out_buffer(i, w.tag);
						break;
					end
			end
			MODE_QUERY: begin
				outbound = {outbound, make_result(KIND_QUERY, 64'd0, w.destination, 8'd0, 1'b1,
					fill_level[d] >= flush_threshold)};
			end
			default: begin
			end
		endcase
	endfunction

	function automatic in_t word_of(input logic [2:0] m, input logic [3:0] d,
			input logic [63:0] v, input logic [7:0] t);
		in_t w;
		w.mode        = m;
		w.destination = d;
		w.value       = v;
		w.tag         = t;
		return w;
	endfunction

	function automatic in_t random_word();
		int pick;
		logic [2:0] m;
		logic [3:0] d;
		pick = $urandom_range(99);
		if (pick < 70)
			m = MODE_ADD;
		else if (pick < 78)
			m = MODE_FLUSH;
		else if (pick < 83)
			m = MODE_FORCE;
		else if (pick < 88)
			m = MODE_ALL;
		else if (pick < 96)
			m = MODE_QUERY;
		else
			m = 3'($urandom_range(7, 5));
		d = ($urandom_range(99) < 55) ? hot_dest : 4'($urandom_range(NDEST - 1));
		return word_of(m, d, {$urandom(), $urandom()}, 8'($urandom_range(255)));
	endfunction

	task automatic send_word(input in_t w);
		int gap;
		gap = 0;
		if (!no_gaps && $urandom_range(99) < 15)
			gap = 1;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		aggregate(w);
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		while (outbound.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] period_val, input logic [CFG_W-1:0] rank_val);
		int p;
		cfg_we <= 1'b1;
		cfg_index <= REG_PERIOD;
		cfg_data <= period_val;
		@(posedge clk);
		cfg_index <= REG_OWN_RANK;
		cfg_data <= rank_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		p = (period_val == 0) ? 1 : int'(period_val);
		flush_threshold = (MAXW / p) * p;
		cur_rank = rank_val[3:0];
	endtask

	task automatic test_directed_ops();
		send_word(word_of(MODE_QUERY, 4'd0, '1, 8'hFF));
		send_word(word_of(MODE_ADD, 4'd0, 64'd0, 8'd0));
		send_word(word_of(MODE_ADD, 4'd0, '1, 8'hFF));
		send_word(word_of(MODE_ADD, 4'd15, 64'h8000_0000_0000_0001, 8'h00));
		send_word(word_of(MODE_QUERY, 4'd0, 64'd0, 8'h5A));
		send_word(word_of(MODE_FLUSH, 4'd0, 64'd0, 8'hFF));
		send_word(word_of(MODE_FORCE, 4'd0, 64'd0, 8'hFF));
		send_word(word_of(MODE_FORCE, 4'd0, 64'd0, 8'h01));
		send_word(word_of(MODE_FLUSH, 4'd0, 64'd0, 8'h02));
		send_word(word_of(3'd5, 4'd15, '1, 8'hFF));
		send_word(word_of(3'd6, 4'd15, '1, 8'hFF));
		send_word(word_of(3'd7, 4'd15, '1, 8'hFF));
		send_word(word_of(MODE_QUERY, 4'd15, 64'd0, 8'd0));
		send_word(word_of(MODE_ALL, 4'd3, 64'd0, 8'hA5));
		send_word(word_of(MODE_ALL, 4'd0, 64'd0, 8'h00));
		send_word(word_of(MODE_QUERY, 4'd15, 64'd0, 8'd0));
	endtask

	task automatic test_full_buffer();
		no_gaps = 1'b1;
		for (int i = 0; i < NSLOT + 2; i++)
			send_word(word_of(MODE_ADD, 4'd9, {$urandom(), $urandom()}, 8'd0));
		send_word(word_of(MODE_QUERY, 4'd9, 64'd0, 8'd0));
		send_word(word_of(MODE_FLUSH, 4'd9, 64'd0, 8'h3C));
		send_word(word_of(MODE_QUERY, 4'd9, 64'd0, 8'd0));
		no_gaps = 1'b0;
	endtask

	task automatic test_config_sweep();
		int periods [8] = '{65, 33, 127, 0, 40, 64, 13, 1};
		int ranks [8] = '{15, 0, 127, 5, 112, 10, 3, 15};
		for (int ph = 0; ph < 8; ph++) begin
			drain_and_settle();
			configure(CFG_W'(periods[ph]), CFG_W'(ranks[ph]));
			hot_dest = 4'($urandom_range(NDEST - 1));
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word(random_word());
		end
	endtask

	always @(posedge clk)
		pop <= no_gaps || ($urandom_range(99) >= 15);

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (outbound.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				oldest = outbound.pop_front();
				report("kind", 64'(oldest.kind), 64'(result.kind));
				report("word", oldest.word, result.word);
				report("dest_out", 64'(oldest.dest_out), 64'(result.dest_out));
				report("tag_out", 64'(oldest.tag_out), 64'(result.tag_out));
				report("source_rank", 64'(oldest.source_rank), 64'(result.source_rank));
				report("last", 64'(oldest.last), 64'(result.last));
				report("needs_flush", 64'(oldest.needs_flush), 64'(result.needs_flush));
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_full_buffer();
		test_config_sweep();
		push <= 1'b0;
		while (outbound.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
